// ===== rtl/wmsp_pkg.sv =====
package wmsp_pkg;

    localparam int MAX_RADIUS_DEF = 64;

    localparam int STR_W    = 31;
    localparam int HOPS_W   = 16;
    localparam int RADIUS_W = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [HOPS_W-1:0] HOPS_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [HOPS_W-1:0] hops;
        logic [STR_W-1:0]  strength;
    } entry_t;

endpackage

// ===== rtl/windowed_max_strength_path_top.sv =====
// Windowed max-strength path.
// Input stream (s_*): one transaction per island, defense in s_tdata, s_tlast on
// the target island that ends a run. Result stream (m_*): one transaction per
// run, issued after the target item: safe flag in m_tuser, hops and remaining
// strength in m_tdata.
// Config port: cfg_wr_en/cfg_index/cfg_wdata; index 0 is radius, 1 is the start
// strength. Write only while idle.
// Each island scans the n most recent window entries, n = min(radius,
// MAX_RADIUS, islands seen in the run); the first item of a run first stores
// the home island. m_tvalid rises from the output register once the scan for
// the target item is done. The window sits in a single-port ring memory and
// the n entries are read one per cycle into the shared compare/subtract unit.
// s_tready is high only between items. A finished result waits in the output
// register while the next run streams in; if it is still not taken when the
// next target item is done, the block holds until m_tready.
// Reset clears the control state; the window needs no clearing pass because
// entries from before a run start are masked by a fill count.
module windowed_max_strength_path_top #(
    parameter int MAX_RADIUS = wmsp_pkg::MAX_RADIUS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [wmsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wmsp_pkg::STR_W-1:0]    cfg_wdata,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [30:0] defense
    input  logic                          s_tlast,   // last

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // [15:0] hops, [46:16] remaining
    output logic                          m_tuser    // safe
);

    localparam int SLOT_W = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
    localparam int CNT_A  = $clog2(MAX_RADIUS + 1);
    localparam int CNT_W  = (CNT_A > wmsp_pkg::RADIUS_W) ? CNT_A : wmsp_pkg::RADIUS_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_RADIUS - 1);
    localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1 % MAX_RADIUS);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_RADIUS);

    wmsp_pkg::state_t state_reg, state_next;

    logic [wmsp_pkg::RADIUS_W-1:0] radius_reg;
    logic [wmsp_pkg::STR_W-1:0]    start_reg;

    logic                          run_open_reg, run_open_next;
    logic [SLOT_W-1:0]             wslot_reg, wslot_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [SLOT_W-1:0]             raddr_reg, raddr_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [wmsp_pkg::STR_W-1:0]    def_reg, def_next;
    logic                          last_reg, last_next;
    logic [wmsp_pkg::STR_W-1:0]    best_reg, best_next;
    logic [wmsp_pkg::HOPS_W-1:0]   bpath_reg, bpath_next;

    logic                          out_vld_reg, out_vld_next;
    logic                          safe_reg, safe_next;
    logic [wmsp_pkg::HOPS_W-1:0]   hops_reg, hops_next;
    logic [wmsp_pkg::STR_W-1:0]    rem_reg, rem_next;

    wmsp_pkg::entry_t              mem [MAX_RADIUS];
    wmsp_pkg::entry_t              rd_data;
    wmsp_pkg::entry_t              wr_data;
    logic [SLOT_W-1:0]             wr_addr;
    logic                          wr_en;
    logic                          rd_en;

    logic [CNT_W-1:0]              rsat;
    logic [CNT_W-1:0]              scan_len;
    logic                          take;
    logic                          s_acc;
    logic                          out_free;
    logic [wmsp_pkg::STR_W-1:0]    new_str;

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] x);
        slot_dec = (x == '0) ? SLOT_LAST : x - SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] x);
        slot_inc = (x == SLOT_LAST) ? '0 : x + SLOT_W'(1);
    endfunction

    assign s_tready = (state_reg == wmsp_pkg::ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign out_free = ~out_vld_reg | m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, rem_reg, hops_reg};
    assign m_tuser  = safe_reg;

    // scan length
    always_comb begin
        rsat     = (CNT_W'(radius_reg) > CNT_MAX) ? CNT_MAX : CNT_W'(radius_reg);
        scan_len = (rsat < fill_reg) ? rsat : fill_reg;
    end

    // shared compare unit
    always_comb begin
        take = rd_vld_reg && (rd_data.strength != '0) &&
               ((rd_data.strength > best_reg) ||
                ((rd_data.strength == best_reg) && (rd_data.hops < bpath_reg)));
        new_str = (best_reg > def_reg) ? best_reg - def_reg : '0;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wmsp_pkg::ST_IDLE: begin
                if (s_acc) begin
                    state_next = run_open_reg ? wmsp_pkg::ST_SCAN : wmsp_pkg::ST_OPEN;
                end
            end
            wmsp_pkg::ST_OPEN: state_next = wmsp_pkg::ST_SCAN;
            wmsp_pkg::ST_SCAN: begin
                if (cnt_reg == scan_len) begin
                    state_next = last_reg ? wmsp_pkg::ST_EMIT : wmsp_pkg::ST_WRITE;
                end
            end
            wmsp_pkg::ST_WRITE: state_next = wmsp_pkg::ST_IDLE;
            wmsp_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = wmsp_pkg::ST_IDLE;
                end
            end
            default: state_next = wmsp_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        run_open_next = run_open_reg;
        wslot_next    = wslot_reg;
        fill_next     = fill_reg;
        raddr_next    = raddr_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        def_next      = def_reg;
        last_next     = last_reg;
        best_next     = take ? rd_data.strength : best_reg;
        bpath_next    = take ? rd_data.hops : bpath_reg;
        out_vld_next  = out_vld_reg & ~m_tready;
        safe_next     = safe_reg;
        hops_next     = hops_reg;
        rem_next      = rem_reg;
        wr_en         = 1'b0;
        wr_addr       = wslot_reg;
        wr_data       = '0;
        rd_en         = 1'b0;

        unique case (state_reg)
            wmsp_pkg::ST_IDLE: begin
                if (s_acc) begin
                    def_next   = s_tdata[wmsp_pkg::STR_W-1:0];
                    last_next  = s_tlast;
                    cnt_next   = '0;
                    best_next  = '0;
                    bpath_next = wmsp_pkg::HOPS_MAX;
                    raddr_next = slot_dec(wslot_reg);
                end
            end
            wmsp_pkg::ST_OPEN: begin
                wr_en            = 1'b1;
                wr_addr          = '0;
                wr_data.strength = start_reg;
                wr_data.hops     = '0;
                wslot_next       = SLOT_ONE;
                fill_next        = CNT_W'(1);
                run_open_next    = 1'b1;
                raddr_next       = slot_dec(SLOT_ONE);
            end
            wmsp_pkg::ST_SCAN: begin
                if (cnt_reg != scan_len) begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    raddr_next  = slot_dec(raddr_reg);
                end
            end
            wmsp_pkg::ST_WRITE: begin
                wr_en            = 1'b1;
                wr_data.strength = new_str;
                if (new_str == '0) begin
                    wr_data.hops = '0;
                end else if (bpath_reg == wmsp_pkg::HOPS_MAX) begin
                    wr_data.hops = wmsp_pkg::HOPS_MAX;
                end else begin
                    wr_data.hops = bpath_reg + wmsp_pkg::HOPS_W'(1);
                end
                wslot_next = slot_inc(wslot_reg);
                fill_next  = (fill_reg == CNT_MAX) ? fill_reg : fill_reg + CNT_W'(1);
            end
            wmsp_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    run_open_next = 1'b0;
                    safe_next     = (best_reg == '0);
                    if (best_reg == '0) begin
                        hops_next = '0;
                    end else if (bpath_reg ==
                                 wmsp_pkg::HOPS_MAX - wmsp_pkg::HOPS_W'(1)) begin
                        hops_next = wmsp_pkg::HOPS_MAX;
                    end else begin
                        hops_next = bpath_reg;
                    end
                    rem_next      = best_reg;
                end
            end
            default: ;
        endcase
    end

    // window ring memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[raddr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wmsp_pkg::ST_IDLE;
            radius_reg   <= wmsp_pkg::RADIUS_W'(1);
            start_reg    <= '0;
            run_open_reg <= 1'b0;
            wslot_reg    <= '0;
            fill_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            run_open_reg <= run_open_next;
            wslot_reg    <= wslot_next;
            fill_reg     <= fill_next;
            rd_vld_reg   <= rd_vld_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_wr_en) begin
                if (cfg_index == wmsp_pkg::REG_RADIUS) begin
                    radius_reg <= cfg_wdata[wmsp_pkg::RADIUS_W-1:0];
                end else if (cfg_index == wmsp_pkg::REG_START) begin
                    start_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        raddr_reg <= raddr_next;
        cnt_reg   <= cnt_next;
        def_reg   <= def_next;
        last_reg  <= last_next;
        best_reg  <= best_next;
        bpath_reg <= bpath_next;
        safe_reg  <= safe_next;
        hops_reg  <= hops_next;
        rem_reg   <= rem_next;
    end

endmodule
